>>> rtl/core/hex6t_pkg.sv
package hex6t_pkg;

   // grid limits and field widths
   localparam int MAX_CELLS_PER_AXIS = 1024;
   localparam int COORD_W            = 10;
   localparam int CNT_W              = 11;
   localparam int START_W            = 31;
   localparam int ID_W               = 32;
   localparam int IDX_W              = 3;
   localparam int ROW_W              = 2 * CNT_W - 1;
   localparam int OFF_W              = 2 * CNT_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_I_CELLS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_J_CELLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_CELLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ID = 3'd3;

   localparam logic [CNT_W-1:0]   CELLS_RESET   = 11'd1;
   localparam logic [START_W-1:0] START_RESET   = 31'd0;
   localparam logic [CNT_W-1:0]   MAX_CELLS     = CNT_W'(MAX_CELLS_PER_AXIS);

   // tetrahedra around the n0-n6 diagonal, named by their two middle corners
   localparam logic [IDX_W-1:0] TET_N1_N2 = 3'd0;
   localparam logic [IDX_W-1:0] TET_N2_N3 = 3'd1;
   localparam logic [IDX_W-1:0] TET_N3_N7 = 3'd2;
   localparam logic [IDX_W-1:0] TET_N7_N4 = 3'd3;
   localparam logic [IDX_W-1:0] TET_N4_N5 = 3'd4;
   localparam logic [IDX_W-1:0] TET_N5_N1 = 3'd5;

   // cell count clipped to the grid limit
   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cells);
      sat_count = (cells > MAX_CELLS) ? MAX_CELLS : cells;
   endfunction

endpackage

>>> rtl/core/hex_cell_to_six_tetra_node_ids_unit.sv
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// req      | req_valid req_stall req_cell_i/j/k      | in
// rsp      | rsp_valid rsp_stall rsp_tetra_index ... | out
// csr      | csr_valid csr_ready csr_index csr_wdata | in
//
// five register stages compute the eight corner ids, then a serializer
// sends six beats per cell (one beat for an out-of-range cell)
// the first beat is valid once the cell has passed stages 1 to 5 into the serializer
// the single result port limits the rate; the serializer loads the next cell on the last beat
// reset clears all stage valid bits and loads the register reset values
// a stall on rsp holds the serializer and backs up the stages one by one
module hex_cell_to_six_tetra_node_ids_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [hex6t_pkg::COORD_W-1:0]        req_cell_i,
   input  logic [hex6t_pkg::COORD_W-1:0]        req_cell_j,
   input  logic [hex6t_pkg::COORD_W-1:0]        req_cell_k,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hex6t_pkg::IDX_W-1:0]          rsp_tetra_index,
   output logic [hex6t_pkg::ID_W-1:0]           rsp_node_a,
   output logic [hex6t_pkg::ID_W-1:0]           rsp_node_b,
   output logic [hex6t_pkg::ID_W-1:0]           rsp_node_c,
   output logic [hex6t_pkg::ID_W-1:0]           rsp_node_d,
   output logic                                 rsp_out_of_range,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hex6t_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hex6t_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic [hex6t_pkg::OFF_W-1:0] s;
      logic [hex6t_pkg::OFF_W-1:0] s_kv;
      logic [hex6t_pkg::OFF_W-1:0] s_1;
      logic [hex6t_pkg::OFF_W-1:0] s_kv_1;
      logic [hex6t_pkg::CNT_W-1:0] kv;
      logic [hex6t_pkg::CNT_W-1:0] kv_1;
   } offs_type;

   typedef struct packed {
      logic [hex6t_pkg::ID_W-1:0] n0;
      logic [hex6t_pkg::ID_W-1:0] n1;
      logic [hex6t_pkg::ID_W-1:0] n2;
      logic [hex6t_pkg::ID_W-1:0] n3;
      logic [hex6t_pkg::ID_W-1:0] n4;
      logic [hex6t_pkg::ID_W-1:0] n5;
      logic [hex6t_pkg::ID_W-1:0] n6;
      logic [hex6t_pkg::ID_W-1:0] n7;
   } corners_type;

   // configuration registers
   logic [hex6t_pkg::CNT_W-1:0]   i_cells_ff;
   logic [hex6t_pkg::CNT_W-1:0]   j_cells_ff;
   logic [hex6t_pkg::CNT_W-1:0]   k_cells_ff;
   logic [hex6t_pkg::START_W-1:0] start_id_ff;

   logic [hex6t_pkg::CNT_W-1:0]   ni;
   logic [hex6t_pkg::CNT_W-1:0]   nj;
   logic [hex6t_pkg::CNT_W-1:0]   nk;
   logic [hex6t_pkg::CNT_W-1:0]   jv;
   logic [hex6t_pkg::CNT_W-1:0]   kv;
   logic                          req_oor;

   // stage 1
   logic                           s1_v_ff;
   logic                           s1_rdy;
   logic                           s1_oor_ff;
   logic [hex6t_pkg::COORD_W-1:0]  s1_cj_ff;
   logic [hex6t_pkg::COORD_W-1:0]  s1_ck_ff;
   logic [hex6t_pkg::CNT_W-1:0]    s1_kv_ff;
   logic [hex6t_pkg::ROW_W-1:0]    s1_prod_ff;
   logic [hex6t_pkg::OFF_W-1:0]    s1_str_ff;

   // stage 2
   logic                           s2_v_ff;
   logic                           s2_rdy;
   logic                           s2_oor_ff;
   logic [hex6t_pkg::COORD_W-1:0]  s2_ck_ff;
   logic [hex6t_pkg::ROW_W-1:0]    s2_row_ff;
   offs_type                       s2_offs_ff;
   offs_type                       s2_offs_in;

   // stage 3
   logic                           s3_v_ff;
   logic                           s3_rdy;
   logic                           s3_oor_ff;
   logic [hex6t_pkg::COORD_W-1:0]  s3_ck_ff;
   logic [hex6t_pkg::ID_W-1:0]     s3_prod_ff;
   offs_type                       s3_offs_ff;

   // stage 4
   logic                           s4_v_ff;
   logic                           s4_rdy;
   logic                           s4_oor_ff;
   logic [hex6t_pkg::ID_W-1:0]     s4_n0_ff;
   offs_type                       s4_offs_ff;

   // stage 5
   logic                           s5_v_ff;
   logic                           s5_rdy;
   logic                           s5_oor_ff;
   corners_type                    s5_n_ff;
   corners_type                    s5_n_in;

   // serializer
   logic                           ser_v_ff;
   logic                           ser_rdy;
   logic                           ser_oor_ff;
   logic [hex6t_pkg::IDX_W-1:0]    ser_cnt_ff;
   corners_type                    ser_n_ff;
   logic                           rsp_beat;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_cells_ff  <= hex6t_pkg::CELLS_RESET;
         j_cells_ff  <= hex6t_pkg::CELLS_RESET;
         k_cells_ff  <= hex6t_pkg::CELLS_RESET;
         start_id_ff <= hex6t_pkg::START_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hex6t_pkg::CSR_I_CELLS:  i_cells_ff  <= csr_wdata[hex6t_pkg::CNT_W-1:0];
            hex6t_pkg::CSR_J_CELLS:  j_cells_ff  <= csr_wdata[hex6t_pkg::CNT_W-1:0];
            hex6t_pkg::CSR_K_CELLS:  k_cells_ff  <= csr_wdata[hex6t_pkg::CNT_W-1:0];
            hex6t_pkg::CSR_START_ID: start_id_ff <= csr_wdata[hex6t_pkg::START_W-1:0];
            default: ;
         endcase
      end
   end

   // clipped counts, vertex strides and range check
   assign ni = hex6t_pkg::sat_count(i_cells_ff);
   assign nj = hex6t_pkg::sat_count(j_cells_ff);
   assign nk = hex6t_pkg::sat_count(k_cells_ff);
   assign jv = nj + hex6t_pkg::CNT_W'(1);
   assign kv = nk + hex6t_pkg::CNT_W'(1);

   assign req_oor = (hex6t_pkg::CNT_W'(req_cell_i) >= ni) ||
                    (hex6t_pkg::CNT_W'(req_cell_j) >= nj) ||
                    (hex6t_pkg::CNT_W'(req_cell_k) >= nk);

   // stall chain: a stage takes new data when empty or when it moves on
   assign ser_rdy   = !ser_v_ff || (!rsp_stall && rsp_last);
   assign s5_rdy    = !s5_v_ff || ser_rdy;
   assign s4_rdy    = !s4_v_ff || s5_rdy;
   assign s3_rdy    = !s3_v_ff || s4_rdy;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
         if (s5_rdy) s5_v_ff <= s4_v_ff;
      end
   end

   // stage 1: i times j stride, and the i step j*k stride
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_oor_ff  <= req_oor;
         s1_cj_ff   <= req_cell_j;
         s1_ck_ff   <= req_cell_k;
         s1_kv_ff   <= kv;
         s1_prod_ff <= hex6t_pkg::ROW_W'(req_cell_i) * hex6t_pkg::ROW_W'(jv);
         s1_str_ff  <= hex6t_pkg::OFF_W'(jv) * hex6t_pkg::OFF_W'(kv);
      end
   end

   // stage 2: row index and the corner offsets from n0
   always_comb begin
      s2_offs_in.s      = s1_str_ff;
      s2_offs_in.s_kv   = s1_str_ff + hex6t_pkg::OFF_W'(s1_kv_ff);
      s2_offs_in.s_1    = s1_str_ff + hex6t_pkg::OFF_W'(1);
      s2_offs_in.s_kv_1 = s1_str_ff + hex6t_pkg::OFF_W'(s1_kv_ff) + hex6t_pkg::OFF_W'(1);
      s2_offs_in.kv     = s1_kv_ff;
      s2_offs_in.kv_1   = s1_kv_ff + hex6t_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_oor_ff  <= s1_oor_ff;
         s2_ck_ff   <= s1_ck_ff;
         s2_row_ff  <= s1_prod_ff + hex6t_pkg::ROW_W'(s1_cj_ff);
         s2_offs_ff <= s2_offs_in;
      end
   end

   // stage 3: row times k stride
   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_oor_ff  <= s2_oor_ff;
         s3_ck_ff   <= s2_ck_ff;
         s3_prod_ff <= hex6t_pkg::ID_W'(s2_row_ff) * hex6t_pkg::ID_W'(s2_offs_ff.kv);
         s3_offs_ff <= s2_offs_ff;
      end
   end

   // stage 4: corner n0 with k and start offset, wraps at 32 bits
   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_oor_ff  <= s3_oor_ff;
         s4_n0_ff   <= s3_prod_ff + hex6t_pkg::ID_W'(s3_ck_ff) +
                       hex6t_pkg::ID_W'(start_id_ff);
         s4_offs_ff <= s3_offs_ff;
      end
   end

   // stage 5: the other seven corners as offsets from n0
   always_comb begin
      s5_n_in.n0 = s4_n0_ff;
      s5_n_in.n1 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.s);
      s5_n_in.n2 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.s_kv);
      s5_n_in.n3 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.kv);
      s5_n_in.n4 = s4_n0_ff + hex6t_pkg::ID_W'(1);
      s5_n_in.n5 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.s_1);
      s5_n_in.n6 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.s_kv_1);
      s5_n_in.n7 = s4_n0_ff + hex6t_pkg::ID_W'(s4_offs_ff.kv_1);
   end

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         s5_oor_ff <= s4_oor_ff;
         s5_n_ff   <= s5_n_in;
      end
   end

   // serializer: one beat per tetrahedron, a single beat for an out-of-range cell
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff   <= 1'b0;
         ser_cnt_ff <= hex6t_pkg::TET_N1_N2;
      end else if (ser_rdy) begin
         ser_v_ff   <= s5_v_ff;
         ser_cnt_ff <= hex6t_pkg::TET_N1_N2;
      end else if (rsp_beat) begin
         ser_cnt_ff <= ser_cnt_ff + hex6t_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_rdy) begin
         ser_oor_ff <= s5_oor_ff;
         ser_n_ff   <= s5_n_ff;
      end
   end

   // result fields
   assign rsp_valid        = ser_v_ff;
   assign rsp_out_of_range = ser_oor_ff;
   assign rsp_last         = ser_oor_ff || (ser_cnt_ff == hex6t_pkg::TET_N5_N1);

   always_comb begin
      rsp_tetra_index = hex6t_pkg::TET_N1_N2;
      rsp_node_a      = '0;
      rsp_node_b      = '0;
      rsp_node_c      = '0;
      rsp_node_d      = '0;
      if (!ser_oor_ff) begin
         rsp_tetra_index = ser_cnt_ff;
         rsp_node_a      = ser_n_ff.n0;
         rsp_node_d      = ser_n_ff.n6;
         unique case (ser_cnt_ff)
            hex6t_pkg::TET_N1_N2: begin
               rsp_node_b = ser_n_ff.n1;
               rsp_node_c = ser_n_ff.n2;
            end
            hex6t_pkg::TET_N2_N3: begin
               rsp_node_b = ser_n_ff.n2;
               rsp_node_c = ser_n_ff.n3;
            end
            hex6t_pkg::TET_N3_N7: begin
               rsp_node_b = ser_n_ff.n3;
               rsp_node_c = ser_n_ff.n7;
            end
            hex6t_pkg::TET_N7_N4: begin
               rsp_node_b = ser_n_ff.n7;
               rsp_node_c = ser_n_ff.n4;
            end
            hex6t_pkg::TET_N4_N5: begin
               rsp_node_b = ser_n_ff.n4;
               rsp_node_c = ser_n_ff.n5;
            end
            hex6t_pkg::TET_N5_N1: begin
               rsp_node_b = ser_n_ff.n5;
               rsp_node_c = ser_n_ff.n1;
            end
            default: begin
               rsp_node_b = '0;
               rsp_node_c = '0;
            end
         endcase
      end
   end

   // an out-of-range cell is one zeroed, final beat
   a_oor_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_last && rsp_tetra_index == hex6t_pkg::TET_N1_N2 &&
         rsp_node_a == '0 && rsp_node_d == '0)
      else $error("out-of-range beat is not a single zeroed beat");

   // within a cell the tetra index steps by one per beat
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_tetra_index == $past(rsp_tetra_index) + hex6t_pkg::IDX_W'(1))
      else $error("tetra index did not advance within a cell");

   // a waiting cell follows the last beat at once, starting from the first tetrahedron
   a_next_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last && s5_v_ff |=>
         rsp_valid && rsp_tetra_index == hex6t_pkg::TET_N1_N2)
      else $error("next cell not started after last beat");

   // a blocked final stage keeps its corners
   a_s5_hold: assert property (@(posedge clock) disable iff (reset)
      s5_v_ff && !ser_rdy |=> s5_v_ff && $stable(s5_n_ff) && $stable(s5_oor_ff))
      else $error("stage 5 lost data under stall");

endmodule
